FILE: design/mhn_pkg.sv
// Shared constants and tables for the hashed name generator.
`timescale 1ns / 1ps
package mhn_pkg;
  localparam int BUF_DEPTH = 64;
  localparam int BUF_WIDTH = 8;
  localparam int NAME_SYMBOLS = 22;
  localparam logic [4:0] REG_DIR_LEVELS = 5'd0;
  localparam logic [4:0] REG_DIR_LENGTH = 5'd1;
  localparam logic [7:0] SLASH_CHAR = 8'h2f;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
          32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
          32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
          32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
          32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
          32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
          32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
          32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
          32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
          32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
          32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return k[i];
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] r [16];
    r = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return r[{i[5:4], i[1:0]}];
  endfunction

  // Message word used by round i.
  function automatic logic [3:0] word_index(input logic [5:0] i);
    logic [3:0] j;
    j = i[3:0];
    unique case (i[5:4])
      2'd0: return j;
      2'd1: return 4'(5 * j + 1);
      2'd2: return 4'(3 * j + 5);
      default: return 4'(7 * j);
    endcase
  endfunction

  function automatic logic [7:0] sym_char(input logic [5:0] v);
    if (v < 6'd26) return 8'(8'h41 + v);
    else if (v < 6'd52) return 8'(8'h61 + v - 6'd26);
    else if (v < 6'd62) return 8'(8'h30 + v - 6'd52);
    else if (v == 6'd62) return 8'h5f;
    else return 8'h40;
  endfunction
endpackage

FILE: design/mhn_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module mhn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: design/md5_hashed_name_generator.sv
// Top level of the hashed name generator: MD5 over key bytes, name encoding.
`timescale 1ns / 1ps
// Each key byte is written into a 64-byte block RAM. When the
// 64th byte of a block lands, compression runs one MD5 round at a time:
// four RAM reads of one message byte each, a fifth step to take the
// last read data, then the round update, up to the final fold.
// The end request pads the block byte by byte into the same RAM, runs the
// final compression(s), and then emits 22 to 44 characters, one per cycle
// while out_ready is high. layout_error is set when dir_levels * dir_length
// exceeds 22 or dir_length is 0 with levels set; slashes are then omitted.
// No new request is taken until the whole name has been delivered.
module md5_hashed_name_generator
  import mhn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] name_byte,
  input  logic       has_byte,
  input  logic       end_of_name,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] name_char,
  output logic       last_char,
  output logic       layout_error,
  input  logic       cfg_we,
  input  logic [4:0] cfg_index,
  input  logic [4:0] cfg_data
);
  localparam int DEPTH = BUF_DEPTH;
  localparam int AW = $clog2(DEPTH);
  localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_LOAD = 3'd2,
                         S_ROUND = 3'd3, S_FOLD = 3'd4, S_EMIT = 3'd5;

  logic [2:0]  state;
  logic [4:0]  dir_levels, dir_length;
  logic [AW-1:0] fill;
  logic [63:0] msg_bits;
  logic [31:0] h0, h1, h2, h3, a, b, c, d, wacc;
  logic [5:0]  round;
  logic [2:0]  sub;      // byte fetch phase within a round
  logic        final_run;  // compressing during padding
  logic        pad_done;   // finished after this compression
  logic [3:0]  pad_pos;    // length bytes written so far
  logic        pad_mark;   // 0x80 still to write
  logic        pad_spill;  // 0x80 left no room; length goes in the next block
  logic [5:0]  out_idx;    // next symbol
  logic [4:0]  grp_cnt, lev_cnt;
  logic        bad;
  logic [5:0]  nchar_left;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  mhn_ram #(.WIDTH(BUF_WIDTH), .DEPTH(DEPTH)) u_buf (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // Digest byte i and symbol extraction.
  logic [127:0] digest;
  assign digest = {h3, h2, h1, h0};
  function automatic logic [7:0] dbyte(input logic [127:0] dg, input logic [4:0] i);
    return dg[8*i +: 8];
  endfunction
  logic [4:0]  sgrp;
  logic [1:0]  spos;
  logic [23:0] trip;
  logic [5:0]  sval;
  always_comb begin
    sgrp = 5'(out_idx >> 2);
    spos = out_idx[1:0];
    trip = {dbyte(digest, 5'(3 * sgrp)), dbyte(digest, 5'(3 * sgrp + 1)),
            dbyte(digest, 5'(3 * sgrp + 2))};
    if (sgrp == 5'd5) begin
      trip = {dbyte(digest, 5'd15), 16'd0};
    end
    unique case (spos)
      2'd0: sval = trip[23:18];
      2'd1: sval = trip[17:12];
      2'd2: sval = trip[11:6];
      default: sval = trip[5:0];
    endcase
  end

  // Round function.
  logic [31:0] f, sum, rot;
  logic [4:0]  s;
  always_comb begin
    unique case (round[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum = a + f + sine_k(round) + wacc;
    s = rot_amt(round);
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  logic slash_now;
  assign slash_now = !bad && (lev_cnt < dir_levels) && (grp_cnt == dir_length);
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign name_char = slash_now ? SLASH_CHAR : sym_char(sval);
  assign last_char = (nchar_left == 6'd1);

  // Message word fetched in the current round; its byte address adds the sub-phase.
  logic [3:0] widx;
  assign widx = word_index(round);

  always_comb begin
    ram_we = 1'b0;
    ram_addr = fill;
    ram_wdata = name_byte;
    unique case (state)
      S_IDLE: ram_we = in_valid && has_byte;
      S_PAD: begin
        ram_we = 1'b1;
        if (pad_mark) ram_wdata = 8'h80;
        else if (fill >= AW'(56) && !pad_done && !pad_spill)
          ram_wdata = msg_bits[8*pad_pos[2:0] +: 8];
        else ram_wdata = 8'h00;
      end
      S_LOAD, S_ROUND: ram_addr = AW'({widx, sub[1:0]});
      default: ram_addr = fill;
    endcase
  end

  // Characters taken by the directory levels: dir_levels times dir_length.
  logic [9:0] prod;
  assign prod = dir_levels * dir_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dir_levels <= '0;
      dir_length <= 5'd1;
      fill <= '0;
      msg_bits <= '0;
      h0 <= 32'h67452301; h1 <= 32'hefcdab89; h2 <= 32'h98badcfe; h3 <= 32'h10325476;
      final_run <= 1'b0;
      pad_done <= 1'b0;
      pad_mark <= 1'b0;
      pad_spill <= 1'b0;
      pad_pos <= '0;
      round <= '0;
      sub <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DIR_LEVELS) dir_levels <= cfg_data;
        else if (cfg_index == REG_DIR_LENGTH) dir_length <= cfg_data;
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          if (has_byte) begin
            fill <= fill + 1'b1;
            msg_bits <= msg_bits + 64'd8;
          end
          if (has_byte && fill == AW'(DEPTH - 1)) begin
            // block full: compress, then resume (or pad if ending)
            final_run <= end_of_name;
            pad_mark <= end_of_name;
            pad_pos <= '0;
            state <= S_LOAD;
            round <= '0; sub <= '0;
            a <= h0; b <= h1; c <= h2; d <= h3;
          end else if (end_of_name) begin
            pad_mark <= 1'b1;
            pad_pos <= '0;
            final_run <= 1'b1;
            pad_done <= 1'b0;
            state <= S_PAD;
          end
        end
        S_PAD: begin
          // advance one pad byte; the length fills bytes 56..63
          pad_mark <= 1'b0;
          fill <= fill + 1'b1;
          if (!pad_mark && !pad_spill && fill >= AW'(56)) pad_pos <= pad_pos + 1'b1;
          if (fill == AW'(DEPTH - 1)) begin
            pad_done <= !pad_mark && !pad_spill;
            pad_spill <= 1'b0;
            state <= S_LOAD;
            round <= '0; sub <= '0;
            a <= h0; b <= h1; c <= h2; d <= h3;
          end else if (pad_mark && fill >= AW'(56)) begin
            pad_spill <= 1'b1;
          end
        end
        S_LOAD: begin
          // sub 0..3 issue reads; results arrive in the next cycle
          sub <= sub + 1'b1;
          if (sub != 3'd0) wacc <= {ram_rdata, wacc[31:8]};
          if (sub == 3'd4) begin
            state <= S_ROUND;
            sub <= '0;
          end
        end
        S_ROUND: begin
          a <= d; d <= c; c <= b;
          b <= b + rot;
          wacc <= '0;
          if (round == 6'd63) state <= S_FOLD;
          else begin
            round <= round + 1'b1;
            state <= S_LOAD;
          end
        end
        S_FOLD: begin
          h0 <= h0 + a; h1 <= h1 + b; h2 <= h2 + c; h3 <= h3 + d;
          fill <= '0;
          if (!final_run) state <= S_IDLE;
          else if (pad_done) state <= S_EMIT;
          else begin
            pad_done <= 1'b0;
            state <= S_PAD;
          end
        end
        S_EMIT: if (out_ready && last_char) begin
          state <= S_IDLE;
          msg_bits <= '0;
          fill <= '0;
          final_run <= 1'b0;
          pad_done <= 1'b0;
          h0 <= 32'h67452301; h1 <= 32'hefcdab89; h2 <= 32'h98badcfe; h3 <= 32'h10325476;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Pad flow: pad_done marks that the length was written in the block now
  // compressing. When the 0x80 lands at byte 56 or later, pad_spill keeps the
  // rest of that block zero and the length moves to the next block.
  // Name emission counters.
  logic bad_next;
  assign bad_next = (prod > 10'(NAME_SYMBOLS)) || (dir_levels != 5'd0 && dir_length == 5'd0);
  always_ff @(posedge clk) begin
    if (state == S_FOLD) begin
      out_idx <= '0;
      grp_cnt <= '0;
      lev_cnt <= '0;
      bad <= bad_next;
      nchar_left <= bad_next ? 6'(NAME_SYMBOLS) : 6'(NAME_SYMBOLS + {1'b0, dir_levels});
    end else if (state == S_EMIT && out_ready) begin
      nchar_left <= nchar_left - 1'b1;
      if (slash_now) begin
        grp_cnt <= '0;
        lev_cnt <= lev_cnt + 1'b1;
      end else begin
        out_idx <= out_idx + 1'b1;
        grp_cnt <= grp_cnt + 1'b1;
      end
    end
  end
  assign layout_error = bad;
endmodule
